// File: hw/rtl/kbc_pkg.sv
// kbc_pkg: shared types, constants and the round/saturate function of the
// kernel bank convolver. No dependencies.
`timescale 1ns / 1ps

package kbc_pkg;

   localparam int MAX_TAPS       = 15;
   localparam int MAX_KERNELS    = 4;
   localparam int MAX_ROW_LENGTH = 65536;
   localparam int OUT_KERNELS    = 4;

   localparam logic MODE_LOAD   = 1'b0;
   localparam logic MODE_SAMPLE = 1'b1;

   localparam logic [1:0] REG_TAP_COUNT    = 2'd0;
   localparam logic [1:0] REG_KERNEL_COUNT = 2'd1;
   localparam logic [1:0] REG_OUTPUT_SHIFT = 2'd2;

   typedef struct packed {
      logic              mode;
      logic [1:0]        kernel_select;
      logic [3:0]        tap_select;
      logic signed [15:0] coefficient;
      logic signed [15:0] sample;
      logic              last_in_row;
   } req_payload_type;

   typedef struct packed {
      logic [15:0]        position;
      logic signed [23:0] kernel_0_value;
      logic signed [23:0] kernel_1_value;
      logic signed [23:0] kernel_2_value;
      logic signed [23:0] kernel_3_value;
      logic               last_of_row;
      logic               row_overflow;
   } rsp_payload_type;

   // data handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic               first_tap;
      logic               last_tap;
      logic [3:0]         tap;
      logic signed [15:0] sample;
   } link_type;

   // round half up, shift right by sh, saturate to 24 bits
   function automatic logic signed [23:0] round_sat(input logic signed [63:0] acc,
                                                    input logic [4:0] sh);
      logic signed [63:0] x;
      logic signed [63:0] r;
      x = acc;
      if (sh != 5'd0) begin
         x = acc + (64'sd1 <<< (sh - 5'd1));
      end
      r = x >>> sh;
      if (r > 64'sd8388607) begin
         return 24'sd8388607;
      end else if (r < -64'sd8388608) begin
         return -24'sd8388608;
      end
      return r[23:0];
   endfunction

endpackage

// File: hw/rtl/kernel_bank_convolver_edge_clamp.sv
// kernel_bank_convolver_edge_clamp: top level of the FIR kernel bank with
// replicated row edges. Depends on kbc_pkg and kbc_cell.
`timescale 1ns / 1ps

// Usage:
//  req channel (valid/ready) carries either a coefficient load (mode 0) or a
//  row sample (mode 1). Loads produce no result.
//  rsp channel (valid/ready) returns one filtered position per transfer with
//  the value of every active kernel; a sample gives zero or one result, the
//  sample marked last_in_row gives every remaining position of the row.
//  csr is an APB-style port: tap_count at 0x0, kernel_count at 0x4,
//  output_shift at 0x8; the user must write it only while the block is idle;
//  the block itself does not enforce this. Each result is computed by a
//  chain of kernel lanes: the sequencer feeds the K taps of a position into
//  the first lane, one per cycle, and each lane passes them on through its
//  link register. Each emitted position goes through the HOLD, ISSUE and
//  WAIT states; the last lane's done flag loads the output register.
//  req_ready is high while no position is being computed, so a new item is
//  taken while a finished result still waits in the output register.
//  When rsp_ready is low, the next position waits until the output register
//  is free. Reset clears the window, row count and valid flags and sets the
//  csr defaults; coefficients must be loaded after reset.
module kernel_bank_convolver_edge_clamp #(
   parameter int MAX_TAPS       = kbc_pkg::MAX_TAPS,
   parameter int MAX_KERNELS    = kbc_pkg::MAX_KERNELS,
   parameter int MAX_ROW_LENGTH = kbc_pkg::MAX_ROW_LENGTH
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  kbc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output kbc_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [3:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   output logic [31:0]              csr_prdata,
   output logic                     csr_pready
);

   localparam int DEPTH = (MAX_TAPS < 15) ? MAX_TAPS : 15;
   localparam int TW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LANES = (MAX_KERNELS < kbc_pkg::OUT_KERNELS) ? MAX_KERNELS
                                                               : kbc_pkg::OUT_KERNELS;
   localparam int NW    = (MAX_ROW_LENGTH > 1) ? $clog2(MAX_ROW_LENGTH) : 1;
   localparam int SW    = $clog2(MAX_ROW_LENGTH + 1);
   localparam int IW    = NW + 6;
   localparam int ACC_W = 33 + $clog2(DEPTH + 1);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_HOLD  = 2'd1;
   localparam logic [1:0] ST_ISSUE = 2'd2;
   localparam logic [1:0] ST_WAIT  = 2'd3;

   // configuration
   logic [3:0] tap_count_ff;
   logic [2:0] kernel_count_ff;
   logic [4:0] output_shift_ff;
   logic       csr_wr;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_count_ff    <= 4'd1;
         kernel_count_ff <= 3'd1;
         output_shift_ff <= 5'd14;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            kbc_pkg::REG_TAP_COUNT:    tap_count_ff    <= csr_pwdata[3:0];
            kbc_pkg::REG_KERNEL_COUNT: kernel_count_ff <= csr_pwdata[2:0];
            kbc_pkg::REG_OUTPUT_SHIFT: output_shift_ff <= csr_pwdata[4:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         kbc_pkg::REG_TAP_COUNT:    csr_prdata = 32'(tap_count_ff);
         kbc_pkg::REG_KERNEL_COUNT: csr_prdata = 32'(kernel_count_ff);
         kbc_pkg::REG_OUTPUT_SHIFT: csr_prdata = 32'(output_shift_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   // effective kernel geometry
   logic [3:0] k_eff;
   logic [2:0] kc_eff;
   logic [3:0] lw;
   logic [3:0] rw;

   always_comb begin
      if (tap_count_ff == 4'd0) begin
         k_eff = 4'd1;
      end else if (32'(tap_count_ff) > DEPTH) begin
         k_eff = 4'(DEPTH);
      end else begin
         k_eff = tap_count_ff;
      end
      if (kernel_count_ff == 3'd0) begin
         kc_eff = 3'd1;
      end else if (32'(kernel_count_ff) > LANES) begin
         kc_eff = 3'(LANES);
      end else begin
         kc_eff = kernel_count_ff;
      end
      lw = (k_eff - 4'd1) >> 1;
      rw = k_eff - 4'd1 - lw;
   end

   // sequencer state
   logic [1:0]         state_ff;
   logic [1:0]         state_in;
   logic signed [15:0] win_ff [DEPTH];
   logic [SW-1:0]      seen_ff;
   logic               ovf_ff;
   logic [NW-1:0]      n_ff;
   logic [NW-1:0]      j_ff;
   logic               last_ff;
   logic [3:0]         tap_ff;

   logic               acc_in;
   logic               sample_in;
   logic [NW-1:0]      n_now;
   logic               n_sat;
   logic               emit_now;
   logic [NW-1:0]      j0;
   logic               lane_done;
   logic               out_free;
   logic               final_pos;
   logic               finish;

   logic               rsp_valid_ff;
   kbc_pkg::rsp_payload_type rsp_data_ff;

   assign req_ready = (state_ff == ST_IDLE);
   assign acc_in    = req_valid & req_ready;
   assign sample_in = acc_in & (req_data.mode == kbc_pkg::MODE_SAMPLE);
   assign out_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      n_sat = (32'(seen_ff) >= MAX_ROW_LENGTH);
      n_now = n_sat ? NW'(MAX_ROW_LENGTH - 1) : NW'(seen_ff);
      emit_now = req_data.last_in_row | (32'(n_now) >= 32'(rw));
      j0 = (32'(n_now) >= 32'(rw)) ? n_now - NW'(rw) : '0;
   end

   // window tap selection for the current position and tap
   logic signed [IW-1:0] ix;
   logic [NW-1:0]        iclamp;
   logic [NW-1:0]        dpos;
   logic [TW-1:0]        dsel;
   kbc_pkg::link_type    link_in;

   always_comb begin
      ix = signed'(IW'(j_ff)) + signed'(IW'(tap_ff)) - signed'(IW'(lw));
      if (ix < 0) begin
         iclamp = '0;
      end else if (ix > signed'(IW'(n_ff))) begin
         iclamp = n_ff;
      end else begin
         iclamp = NW'(ix);
      end
      dpos = n_ff - iclamp;
      if (32'(dpos) > DEPTH - 1) begin
         dsel = TW'(DEPTH - 1);
      end else begin
         dsel = TW'(dpos);
      end
      link_in.valid     = (state_ff == ST_ISSUE);
      link_in.first_tap = (tap_ff == 4'd0);
      link_in.last_tap  = (tap_ff == k_eff - 4'd1);
      link_in.tap       = tap_ff;
      link_in.sample    = win_ff[dsel];
   end

   // kernel lanes
   kbc_pkg::link_type       links [LANES];
   logic                    dones [LANES];
   logic signed [ACC_W-1:0] accs  [kbc_pkg::OUT_KERNELS];

   for (genvar l = 0; l < kbc_pkg::OUT_KERNELS; l++) begin : g_lane
      if (l < LANES) begin : g_cell
         logic wr_en;
         assign wr_en = acc_in & (req_data.mode == kbc_pkg::MODE_LOAD) &
                        (32'(req_data.kernel_select) == l) &
                        (32'(req_data.tap_select) < DEPTH);
         kbc_cell #(
            .DEPTH (DEPTH),
            .TW    (TW),
            .ACC_W (ACC_W)
         ) u_cell (
            .clock    (clock),
            .reset    (reset),
            .wr_en    (wr_en),
            .wr_tap   (TW'(req_data.tap_select)),
            .wr_data  (req_data.coefficient),
            .link_in  ((l == 0) ? link_in : links[(l == 0) ? 0 : l - 1]),
            .link_out (links[l]),
            .done     (dones[l]),
            .acc      (accs[l])
         );
      end else begin : g_none
         assign accs[l] = '0;
      end
   end

   // a plain sample emits one position, the row end runs up to n
   assign final_pos = ~last_ff | (j_ff == n_ff);
   assign lane_done = dones[LANES-1];
   assign finish    = (state_ff == ST_WAIT) & lane_done & final_pos;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:  if (sample_in & emit_now) state_in = ST_HOLD;
         ST_HOLD:  if (out_free) state_in = ST_ISSUE;
         ST_ISSUE: if (tap_ff == k_eff - 4'd1) state_in = ST_WAIT;
         ST_WAIT:  if (lane_done) state_in = final_pos ? ST_IDLE : ST_HOLD;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         seen_ff  <= '0;
         ovf_ff   <= 1'b0;
         for (int d = 0; d < DEPTH; d++) begin
            win_ff[d] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (sample_in) begin
            win_ff[0] <= req_data.sample;
            for (int d = 1; d < DEPTH; d++) begin
               win_ff[d] <= win_ff[d-1];
            end
            if (n_sat) begin
               ovf_ff <= 1'b1;
            end else begin
               seen_ff <= seen_ff + SW'(1);
            end
         end else if (finish & last_ff) begin
            seen_ff <= '0;
            ovf_ff  <= 1'b0;
            for (int d = 0; d < DEPTH; d++) begin
               win_ff[d] <= '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (sample_in) begin
         n_ff    <= n_now;
         j_ff    <= j0;
         last_ff <= req_data.last_in_row;
      end else if ((state_ff == ST_WAIT) & lane_done & ~final_pos) begin
         j_ff <= j_ff + NW'(1);
      end
      if (state_ff == ST_HOLD) begin
         tap_ff <= 4'd0;
      end else if (state_ff == ST_ISSUE) begin
         tap_ff <= tap_ff + 4'd1;
      end
   end

   // output register
   logic signed [23:0] vals [kbc_pkg::OUT_KERNELS];

   always_comb begin
      for (int l = 0; l < kbc_pkg::OUT_KERNELS; l++) begin
         if (l < 32'(kc_eff)) begin
            vals[l] = kbc_pkg::round_sat(64'(accs[l]), output_shift_ff);
         end else begin
            vals[l] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (lane_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (lane_done) begin
         rsp_data_ff.position <= (32'(j_ff) > 32'd65535) ? 16'hFFFF : 16'(j_ff);
         rsp_data_ff.kernel_0_value <= vals[0];
         rsp_data_ff.kernel_1_value <= vals[1];
         rsp_data_ff.kernel_2_value <= vals[2];
         rsp_data_ff.kernel_3_value <= vals[3];
         rsp_data_ff.last_of_row    <= last_ff & (j_ff == n_ff);
         rsp_data_ff.row_overflow   <= ovf_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      lane_done |-> (!rsp_valid_ff || rsp_ready))
      else $error("result lands on an untaken result");

   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      lane_done |-> (state_ff == ST_WAIT))
      else $error("lane result outside wait state");

   a_tap_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (tap_ff < k_eff))
      else $error("tap index beyond tap count");

   a_busy_no_accept: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE || state_ff == ST_WAIT) |-> !req_ready)
      else $error("item taken while a position is in flight");

endmodule

// File: hw/rtl/kbc_cell.sv
// kbc_cell: one kernel lane of the convolver chain: coefficient bank,
// multiplier and accumulator; forwards the sample link to the next lane.
// Depends on kbc_pkg.
`timescale 1ns / 1ps

module kbc_cell #(
   parameter int DEPTH = 15,
   parameter int TW    = 4,
   parameter int ACC_W = 36
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  logic [TW-1:0]           wr_tap,
   input  logic signed [15:0]      wr_data,
   input  kbc_pkg::link_type       link_in,
   output kbc_pkg::link_type       link_out,
   output logic                    done,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [15:0]      coef_ff [DEPTH];
   kbc_pkg::link_type       link_ff;
   logic signed [31:0]      prod_ff;
   logic                    pvalid_ff;
   logic                    pfirst_ff;
   logic                    pfinal_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [ACC_W-1:0] acc_in;
   logic                    done_ff;

   always_comb begin
      acc_in = pfirst_ff ? ACC_W'(prod_ff) : acc_ff + ACC_W'(prod_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff.valid <= 1'b0;
         pvalid_ff     <= 1'b0;
         done_ff       <= 1'b0;
      end else begin
         link_ff.valid <= link_in.valid;
         pvalid_ff     <= link_in.valid;
         done_ff       <= pvalid_ff & pfinal_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         coef_ff[wr_tap] <= wr_data;
      end
      link_ff.first_tap <= link_in.first_tap;
      link_ff.last_tap  <= link_in.last_tap;
      link_ff.tap       <= link_in.tap;
      link_ff.sample    <= link_in.sample;
      prod_ff   <= coef_ff[link_in.tap[TW-1:0]] * link_in.sample;
      pfirst_ff <= link_in.first_tap;
      pfinal_ff <= link_in.last_tap;
      if (pvalid_ff) begin
         acc_ff <= acc_in;
      end
   end

   assign link_out = link_ff;
   assign done     = done_ff;
   assign acc      = acc_ff;

endmodule

// File: tb/kbc_checker.sv
// kbc_checker: watches the req, rsp and csr ports of the kernel bank convolver.
// It predicts every filtered position and compares each rsp transfer with it.
// Depends on kbc_pkg.
`timescale 1ns / 1ps

module kbc_checker (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  kbc_pkg::req_payload_type req_data,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  kbc_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [3:0]               csr_paddr,
   input  logic [31:0]              csr_pwdata,
   input  logic                     csr_pready,
   output int                       fail_count,
   output int                       pending
);

   logic signed [15:0] coef_mem [kbc_pkg::MAX_KERNELS][kbc_pkg::MAX_TAPS];
   logic signed [15:0] row_window [kbc_pkg::MAX_TAPS];
   int unsigned        row_seen;
   logic               row_ovf;
   logic [3:0]         taps_cfg;
   logic [2:0]         kernels_cfg;
   logic [4:0]         shift_cfg;
   kbc_pkg::rsp_payload_type expected_positions [$];
   int                 errors;

   function automatic logic signed [23:0] scale_sum(longint acc);
      longint r;
      if (shift_cfg == 5'd0) begin
         r = acc;
      end else begin
         r = (acc + (64'sd1 <<< (shift_cfg - 5'd1))) >>> shift_cfg;
      end
      if (r > 64'sd8388607) r = 64'sd8388607;
      if (r < -64'sd8388608) r = -64'sd8388608;
      return r[23:0];
   endfunction

   function automatic kbc_pkg::rsp_payload_type filter_position(int unsigned j,
                                                                int unsigned n,
                                                                int k, int lw, int kc,
                                                                bit last);
      kbc_pkg::rsp_payload_type o;
      longint          acc;
      longint          i;
      int              d;
      logic signed [23:0] v [kbc_pkg::OUT_KERNELS];
      for (int l = 0; l < kbc_pkg::OUT_KERNELS; l++) begin
         acc = 0;
         v[l] = '0;
         if (l < kc) begin
            for (int t = 0; t < k; t++) begin
               i = longint'(j) + t - lw;
               if (i < 0) i = 0;
               if (i > longint'(n)) i = n;
               d = n - i;
               if (d >= kbc_pkg::MAX_TAPS) d = kbc_pkg::MAX_TAPS - 1;
               acc += longint'(coef_mem[l][t]) * longint'(row_window[d]);
            end
            v[l] = scale_sum(acc);
         end
      end
      o.position       = j > 65535 ? 16'hFFFF : j[15:0];
      o.kernel_0_value = v[0];
      o.kernel_1_value = v[1];
      o.kernel_2_value = v[2];
      o.kernel_3_value = v[3];
      o.last_of_row    = last && (j == n);
      o.row_overflow   = row_ovf;
      return o;
   endfunction

   task automatic take_request(kbc_pkg::req_payload_type r);
      int          k;
      int          kc;
      int          lw;
      int          rw;
      int unsigned n;
      int unsigned start;
      if (r.mode == kbc_pkg::MODE_LOAD) begin
         if (r.tap_select < kbc_pkg::MAX_TAPS)
            coef_mem[r.kernel_select][r.tap_select] = r.coefficient;
         return;
      end
      k  = taps_cfg == 0 ? 1 : (taps_cfg > kbc_pkg::MAX_TAPS ? kbc_pkg::MAX_TAPS : taps_cfg);
      kc = kernels_cfg == 0 ? 1 :
           (kernels_cfg > kbc_pkg::MAX_KERNELS ? kbc_pkg::MAX_KERNELS : kernels_cfg);
      lw = (k - 1) / 2;
      rw = k - 1 - lw;
      for (int d = kbc_pkg::MAX_TAPS - 1; d > 0; d--) row_window[d] = row_window[d-1];
      row_window[0] = r.sample;
      n = row_seen;
      if (n >= kbc_pkg::MAX_ROW_LENGTH) begin
         row_ovf = 1'b1;
         n = kbc_pkg::MAX_ROW_LENGTH - 1;
      end else begin
         row_seen = n + 1;
      end
      if (!r.last_in_row) begin
         if (n >= rw) expected_positions.push_back(filter_position(n - rw, n, k, lw, kc, 0));
         return;
      end
      start = n >= rw ? n - rw : 0;
      for (int unsigned j = start; j <= n; j++)
         expected_positions.push_back(filter_position(j, n, k, lw, kc, 1));
      row_seen = 0;
      row_ovf  = 1'b0;
      foreach (row_window[d]) row_window[d] = '0;
   endtask

   task automatic check_result(kbc_pkg::rsp_payload_type got);
      kbc_pkg::rsp_payload_type e;
      if (expected_positions.size() == 0) begin
         $error("unexpected rsp transfer at position %0d", got.position);
         errors++;
         return;
      end
      e = expected_positions.pop_front();
      if (got.position != e.position) begin
         $error("position expected %0d actual %0d", e.position, got.position);
         errors++;
      end
      if (got.kernel_0_value != e.kernel_0_value) begin
         $error("kernel_0_value expected %0d actual %0d", e.kernel_0_value,
                got.kernel_0_value);
         errors++;
      end
      if (got.kernel_1_value != e.kernel_1_value) begin
         $error("kernel_1_value expected %0d actual %0d", e.kernel_1_value,
                got.kernel_1_value);
         errors++;
      end
      if (got.kernel_2_value != e.kernel_2_value) begin
         $error("kernel_2_value expected %0d actual %0d", e.kernel_2_value,
                got.kernel_2_value);
         errors++;
      end
      if (got.kernel_3_value != e.kernel_3_value) begin
         $error("kernel_3_value expected %0d actual %0d", e.kernel_3_value,
                got.kernel_3_value);
         errors++;
      end
      if (got.last_of_row != e.last_of_row) begin
         $error("last_of_row expected %0d actual %0d", e.last_of_row, got.last_of_row);
         errors++;
      end
      if (got.row_overflow != e.row_overflow) begin
         $error("row_overflow expected %0d actual %0d", e.row_overflow, got.row_overflow);
         errors++;
      end
   endtask

   initial begin
      errors     = 0;
      fail_count = 0;
      pending    = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         foreach (row_window[d]) row_window[d] = '0;
         foreach (coef_mem[l, t]) coef_mem[l][t] = '0;
         row_seen    = 0;
         row_ovf     = 1'b0;
         taps_cfg    = 4'd1;
         kernels_cfg = 3'd1;
         shift_cfg   = 5'd14;
         expected_positions.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[3:2])
               kbc_pkg::REG_TAP_COUNT:    taps_cfg    = csr_pwdata[3:0];
               kbc_pkg::REG_KERNEL_COUNT: kernels_cfg = csr_pwdata[2:0];
               kbc_pkg::REG_OUTPUT_SHIFT: shift_cfg   = csr_pwdata[4:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_request(req_data);
         if (rsp_valid && rsp_ready) check_result(rsp_data);
      end
      pending    <= expected_positions.size();
      fail_count <= errors;
   end

endmodule

// File: tb/tb_kernel_bank_convolver_edge_clamp.sv
// tb_kernel_bank_convolver_edge_clamp: drives coefficient loads, rows and csr
// writes into the kernel bank convolver and gives the verdict.
// Depends on kbc_pkg, kbc_checker and the block itself.
`timescale 1ns / 1ps

module tb_kernel_bank_convolver_edge_clamp;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int SETTLE_CYCLES  = 250;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   kbc_pkg::req_payload_type req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   kbc_pkg::rsp_payload_type rsp_data;
   logic            csr_psel;
   logic            csr_penable;
   logic            csr_pwrite;
   logic [3:0]      csr_paddr;
   logic [31:0]     csr_pwdata;
   logic [31:0]     csr_prdata;
   logic            csr_pready;
   int              fail_count;
   int              pending;
   int              send_idle_pct;
   int              stall_pct;
   bit              hold_go;
   int              hold_left;
   int              quiet_cycles;

   kernel_bank_convolver_edge_clamp dut (.*);

   kbc_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_pready(csr_pready),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      logic next_ready;
      next_ready = ($urandom_range(99) >= stall_pct);
      if (hold_go) begin
         hold_go   = 1'b0;
         hold_left = 400;
      end
      if (hold_left > 0) begin
         hold_left--;
         next_ready = 1'b0;
      end
      rsp_ready <= next_ready;
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send(kbc_pkg::req_payload_type p);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= p;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic load_coef(logic [1:0] ks, logic [3:0] ts, logic signed [15:0] c);
      kbc_pkg::req_payload_type p;
      p = '0;
      p.mode          = kbc_pkg::MODE_LOAD;
      p.kernel_select = ks;
      p.tap_select    = ts;
      p.coefficient   = c;
      p.sample        = $urandom;
      p.last_in_row   = $urandom_range(1);
      send(p);
   endtask

   task automatic send_sample(logic signed [15:0] s, bit last);
      kbc_pkg::req_payload_type p;
      p.mode          = kbc_pkg::MODE_SAMPLE;
      p.kernel_select = $urandom;
      p.tap_select    = $urandom;
      p.coefficient   = $urandom;
      p.sample        = s;
      p.last_in_row   = last;
      send(p);
   endtask

   task automatic random_row(int len);
      for (int i = 0; i < len; i++) send_sample($urandom, i == len - 1);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(logic [1:0] idx, logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic configure(int taps, int kernels, int shift);
      csr_write(kbc_pkg::REG_TAP_COUNT, taps);
      csr_write(kbc_pkg::REG_KERNEL_COUNT, kernels);
      csr_write(kbc_pkg::REG_OUTPUT_SHIFT, shift);
   endtask

   initial begin
      int pct_send [4] = '{0, 60, 0, 24};
      int pct_stall [4] = '{0, 0, 60, 24};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_data    = '0;
      rsp_ready   = 1'b0;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      send_idle_pct = 0;
      stall_pct     = 0;
      hold_go       = 1'b0;
      hold_left     = 0;
      quiet_cycles  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // every coefficient written before any sample, extremes included
      for (int l = 0; l < kbc_pkg::MAX_KERNELS; l++)
         for (int t = 0; t < kbc_pkg::MAX_TAPS; t++)
            load_coef(l, t, (t == 0) ? 16'sh7FFF : (t == 1) ? 16'sh8000 : $urandom);
      load_coef(2'd3, 4'd15, 16'sh1234);
      settle();

      // directed rows
      configure(15, 4, 0);
      send_sample(16'sh7FFF, 1'b1);
      send_sample(16'sh8000, 1'b0);
      send_sample(16'sh7FFF, 1'b1);
      for (int i = 0; i < 6; i++) send_sample(i[0] ? 16'sh8000 : 16'sh7FFF, i == 5);
      settle();
      configure(1, 1, 30);
      send_sample(16'sh7FFF, 1'b0);
      send_sample(16'sh0000, 1'b0);
      send_sample(16'sh8000, 1'b1);
      settle();

      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct = pct_send[ph];
         stall_pct     = pct_stall[ph];
         for (int c = 0; c < 2; c++) begin
            settle();
            if (ph == 0 && c == 0) configure(15, 4, 30);
            else if (ph == 0) configure(1, 1, 0);
            else configure($urandom_range(15, 1), $urandom_range(4, 1),
                           $urandom_range(30));
            if (ph == 0 && c == 0) begin
               hold_go = 1'b1;
               random_row(30);
            end
            for (int r = 0; r < 5; r++) begin
               if ($urandom_range(9) == 0)
                  load_coef($urandom, $urandom_range(15), $urandom);
               random_row($urandom_range(9) == 0 ? $urandom_range(40, 20)
                                                 : $urandom_range(12, 1));
            end
         end
      end

      settle();
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: files.f
hw/rtl/kbc_pkg.sv
hw/rtl/kbc_cell.sv
hw/rtl/kernel_bank_convolver_edge_clamp.sv
tb/kbc_checker.sv
tb/tb_kernel_bank_convolver_edge_clamp.sv
